// ----- hdl/nrp_pkg.sv -----
// Package with the shared types, constants, microprogram and arithmetic helpers.
`default_nettype none
package nrp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW = 5;
  localparam int PC_W = 7;

  localparam logic [11:0] MAX_ITER_RST = 12'd500;
  localparam logic [47:0] STEP_TOL_RST = 48'd2814750;
  localparam logic [47:0] NORM_LIM_RST = 48'd2814750;

  localparam logic signed [63:0] WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_STEP_TOL = 2'd1,
    CFG_NORM_LIM = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_SINGULAR  = 2'd2
  } finish_e;

  typedef enum logic [RF_AW-1:0] {
    R_A, R_B, R_C, R_D, R_X, R_Y, R_ZERO, R_XX, R_YY, R_XY, R_RA, R_RD,
    R_BC, R_G0, R_G1, R_H00, R_H01, R_H11, R_DET, R_S0, R_S1, R_T0, R_T1, R_T2
  } reg_e;

  typedef enum logic [3:0] {
    OP_LOOP, OP_ADD, OP_SUB, OP_ADD32, OP_UADD, OP_MUL, OP_SQD, OP_DIV,
    OP_CHKDET, OP_CHKSTEP, OP_OUTXY, OP_OUTN
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_WAIT
  } state_e;

  typedef struct packed {
    op_e  op;
    reg_e dst;
    reg_e sa;
    reg_e sb;
  } uop_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [PC_W-1:0] FIN_PC = 7'd65;

  function automatic uop_t mk(input op_e o, input reg_e d, input reg_e a, input reg_e b);
    uop_t u;
    u.op = o;
    u.dst = d;
    u.sa = a;
    u.sb = b;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_LOOP, R_T0, R_ZERO, R_ZERO);
      7'd1:  u = mk(OP_MUL, R_XX, R_X, R_X);
      7'd2:  u = mk(OP_MUL, R_YY, R_Y, R_Y);
      7'd3:  u = mk(OP_MUL, R_XY, R_X, R_Y);
      7'd4:  u = mk(OP_SUB, R_RA, R_A, R_XX);
      7'd5:  u = mk(OP_SUB, R_RD, R_D, R_YY);
      7'd6:  u = mk(OP_SUB, R_T0, R_B, R_XY);
      7'd7:  u = mk(OP_SUB, R_T1, R_C, R_XY);
      7'd8:  u = mk(OP_ADD, R_BC, R_T0, R_T1);
      7'd9:  u = mk(OP_MUL, R_T0, R_X, R_RA);
      7'd10: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd11: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd12: u = mk(OP_MUL, R_T1, R_Y, R_BC);
      7'd13: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd14: u = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd15: u = mk(OP_SUB, R_G0, R_ZERO, R_T0);
      7'd16: u = mk(OP_MUL, R_T0, R_X, R_BC);
      7'd17: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd18: u = mk(OP_MUL, R_T1, R_Y, R_RD);
      7'd19: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd20: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd21: u = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd22: u = mk(OP_SUB, R_G1, R_ZERO, R_T0);
      7'd23: u = mk(OP_ADD, R_T0, R_XX, R_XX);
      7'd24: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd25: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd26: u = mk(OP_ADD, R_T1, R_RA, R_RA);
      7'd27: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd28: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      7'd29: u = mk(OP_ADD, R_T1, R_YY, R_YY);
      7'd30: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd31: u = mk(OP_ADD, R_H00, R_T0, R_T1);
      7'd32: u = mk(OP_ADD, R_T0, R_XY, R_XY);
      7'd33: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd34: u = mk(OP_ADD, R_T1, R_BC, R_BC);
      7'd35: u = mk(OP_SUB, R_H01, R_T0, R_T1);
      7'd36: u = mk(OP_ADD, R_T0, R_XX, R_XX);
      7'd37: u = mk(OP_ADD, R_T0, R_T0, R_T0);
      7'd38: u = mk(OP_ADD, R_T1, R_YY, R_YY);
      7'd39: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd40: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd41: u = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd42: u = mk(OP_ADD, R_T1, R_RD, R_RD);
      7'd43: u = mk(OP_ADD, R_T1, R_T1, R_T1);
      7'd44: u = mk(OP_SUB, R_H11, R_T0, R_T1);
      7'd45: u = mk(OP_MUL, R_T0, R_H00, R_H11);
      7'd46: u = mk(OP_MUL, R_T1, R_H01, R_H01);
      7'd47: u = mk(OP_SUB, R_DET, R_T0, R_T1);
      7'd48: u = mk(OP_CHKDET, R_T0, R_DET, R_ZERO);
      7'd49: u = mk(OP_MUL, R_T0, R_G1, R_H01);
      7'd50: u = mk(OP_MUL, R_T1, R_G0, R_H11);
      7'd51: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      7'd52: u = mk(OP_DIV, R_S0, R_T0, R_DET);
      7'd53: u = mk(OP_MUL, R_T0, R_G0, R_H01);
      7'd54: u = mk(OP_MUL, R_T1, R_G1, R_H00);
      7'd55: u = mk(OP_SUB, R_T0, R_T0, R_T1);
      7'd56: u = mk(OP_DIV, R_S1, R_T0, R_DET);
      7'd57: u = mk(OP_ADD32, R_T0, R_X, R_S0);
      7'd58: u = mk(OP_ADD32, R_T1, R_Y, R_S1);
      7'd59: u = mk(OP_SQD, R_T2, R_T0, R_X);
      7'd60: u = mk(OP_SQD, R_S0, R_T1, R_Y);
      7'd61: u = mk(OP_UADD, R_T2, R_T2, R_S0);
      7'd62: u = mk(OP_ADD, R_X, R_T0, R_ZERO);
      7'd63: u = mk(OP_ADD, R_Y, R_T1, R_ZERO);
      7'd64: u = mk(OP_CHKSTEP, R_T0, R_T2, R_ZERO);
      7'd65: u = mk(OP_SQD, R_T0, R_X, R_ZERO);
      7'd66: u = mk(OP_SQD, R_T1, R_Y, R_ZERO);
      7'd67: u = mk(OP_UADD, R_T0, R_T0, R_T1);
      7'd68: u = mk(OP_OUTXY, R_T0, R_X, R_Y);
      7'd69: u = mk(OP_OUTN, R_T0, R_T0, R_ZERO);
      default: u = mk(OP_OUTN, R_T0, R_T0, R_ZERO);
    endcase
    return u;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    return r;
  endfunction

  function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
    logic signed [63:0] r;
    r = m[63] ? WMAX : $signed(m);
    return neg ? -r : r;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] p,
                                              input logic signed [63:0] q);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {p[63], p} + {q[63], q};
    if (!s[64] && s[63]) begin
      r = WMAX;
    end else if (s[64] && (!s[63] || (s[62:0] == 63'd0))) begin
      r = -WMAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/nrp_if.sv -----
// Valid/ready channel interfaces for the input matrix items and the result items.
`default_nettype none
interface nrp_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] entry_00;
  logic signed [31:0] entry_10;
  logic signed [31:0] entry_01;
  logic signed [31:0] entry_11;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  modport source (output valid, entry_00, entry_10, entry_01, entry_11, start_x, start_y,
                  input ready);
  modport sink (input valid, entry_00, entry_10, entry_01, entry_11, start_x, start_y,
                output ready);
endinterface

interface nrp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic [11:0] iterations_used;
  logic [1:0] finish_status;
  logic degenerate;
  modport source (output valid, result_x, result_y, iterations_used, finish_status,
                  degenerate, input ready);
  modport sink (input valid, result_x, result_y, iterations_used, finish_status,
                degenerate, output ready);
endinterface
`default_nettype wire

// ----- hdl/newton_rank1_projection_2x2.sv -----
// Top level: microcoded sequencer, register file and shared units of the rank-one Newton solver.
// The block takes one 2x2 matrix and a start vector per transaction on in_ch and returns
// one result transaction on out_ch holding the final vector, the iteration count, the
// finish status and the degenerate flag. Configuration registers are written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must do so only while the block is idle,
// which the block itself does not enforce. An item is loaded into a 32-entry register
// file. Each Newton iteration is a 65-step microprogram run on one saturating adder,
// one multi-cycle multiplier and one bit-serial divider; the two divisions dominate
// its run time. After the last iteration, wrap-up steps compute the squared norm and
// hand the result to the output register.
// in_ch.ready is high only while no item is in work, so items are handled one at a time.
// The result sits in an output register; the next item is accepted while it waits, and
// the sequencer holds at its last step if the previous result has not been taken.
// Reset clears the sequencer and output valid and restores the default configuration.
`default_nettype none
module newton_rank1_projection_2x2 #(
  parameter int FRAC_BITS = nrp_pkg::FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nrp_in_if.sink    in_ch,
  nrp_out_if.source out_ch,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [47:0] cfg_wdata_i
);

  nrp_pkg::state_e state_q, state_d;
  logic [nrp_pkg::PC_W-1:0] pc_q, pc_d;
  logic [11:0] used_q, used_d;
  logic [1:0] status_q, status_d;
  logic [2:0] load_q, load_d;
  logic sqov_q, sqov_d;
  logic [11:0] max_q;
  logic [47:0] tol_q, lim_q;
  logic signed [31:0] in_q [6];
  logic [63:0] rf_mem [nrp_pkg::RF_DEPTH];
  logic signed [63:0] rd_a_q, rd_b_q;
  logic we;
  logic [nrp_pkg::RF_AW-1:0] waddr;
  logic signed [63:0] wdata;
  nrp_pkg::uop_t uop;
  logic mul_start, mul_raw, div_start;
  logic signed [63:0] mul_a, mul_b, mul_res, div_res;
  nrp_pkg::unit_stat_t mul_st, div_st;
  logic signed [31:0] fin_x_q, fin_x_d, fin_y_q, fin_y_d;
  logic out_load, out_valid_q, degen;
  logic signed [31:0] out_x_q, out_y_q;
  logic [11:0] out_used_q;
  logic [1:0] out_status_q;
  logic out_degen_q;
  logic signed [63:0] diff;
  logic [63:0] diff_mag;
  logic [64:0] usum;

  assign uop = nrp_pkg::uop_at(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= nrp_pkg::MAX_ITER_RST;
      tol_q <= nrp_pkg::STEP_TOL_RST;
      lim_q <= nrp_pkg::NORM_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nrp_pkg::CFG_MAX_ITER: max_q <= cfg_wdata_i[11:0];
        nrp_pkg::CFG_STEP_TOL: tol_q <= cfg_wdata_i;
        nrp_pkg::CFG_NORM_LIM: lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q[0] <= in_ch.entry_00;
      in_q[1] <= in_ch.entry_10;
      in_q[2] <= in_ch.entry_01;
      in_q[3] <= in_ch.entry_11;
      in_q[4] <= in_ch.start_x;
      in_q[5] <= in_ch.start_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rf_mem[waddr] <= wdata;
    end
    rd_a_q <= rf_mem[uop.sa];
    rd_b_q <= rf_mem[uop.sb];
  end

  nrp_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk_i, .rst_ni, .start_i(mul_start), .raw_i(mul_raw), .a_i(mul_a), .b_i(mul_b),
    .result_o(mul_res), .stat_o(mul_st)
  );

  nrp_fdiv #(.FRAC_BITS(FRAC_BITS)) u_fdiv (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(rd_a_q), .d_i(rd_b_q),
    .result_o(div_res), .stat_o(div_st)
  );

  assign diff = rd_a_q - rd_b_q;
  assign diff_mag = nrp_pkg::mag64(diff);
  assign usum = {1'b0, rd_a_q} + {1'b0, rd_b_q};
  assign degen = 64'(rd_a_q) < {16'd0, lim_q};
  assign in_ch.ready = (state_q == nrp_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrp_pkg::S_IDLE;
      pc_q <= '0;
      used_q <= 12'd0;
      status_q <= nrp_pkg::ST_LIMIT;
      load_q <= 3'd0;
      sqov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      used_q <= used_d;
      status_q <= status_d;
      load_q <= load_d;
      sqov_q <= sqov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_x_q <= fin_x_d;
    fin_y_q <= fin_y_d;
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    used_d = used_q;
    status_d = status_q;
    load_d = load_q;
    sqov_d = sqov_q;
    fin_x_d = fin_x_q;
    fin_y_d = fin_y_q;
    we = 1'b0;
    waddr = uop.dst;
    wdata = rd_a_q;
    mul_start = 1'b0;
    mul_raw = 1'b0;
    mul_a = rd_a_q;
    mul_b = rd_b_q;
    div_start = 1'b0;
    out_load = 1'b0;
    case (state_q)
      nrp_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_d = nrp_pkg::S_LOAD;
          load_d = 3'd0;
        end
      end
      nrp_pkg::S_LOAD: begin
        we = 1'b1;
        waddr = nrp_pkg::RF_AW'(load_q);
        wdata = (load_q <= 3'd5) ? 64'(in_q[load_q]) : 64'sd0;
        load_d = load_q + 3'd1;
        if (load_q == 3'd6) begin
          state_d = nrp_pkg::S_FETCH;
          pc_d = '0;
          used_d = 12'd0;
        end
      end
      nrp_pkg::S_FETCH: begin
        state_d = nrp_pkg::S_EXEC;
      end
      nrp_pkg::S_EXEC: begin
        state_d = nrp_pkg::S_FETCH;
        pc_d = pc_q + nrp_pkg::PC_W'(1);
        case (uop.op)
          nrp_pkg::OP_LOOP: begin
            if (used_q < max_q) begin
              used_d = used_q + 12'd1;
            end else begin
              status_d = nrp_pkg::ST_LIMIT;
              pc_d = nrp_pkg::FIN_PC;
            end
          end
          nrp_pkg::OP_ADD: begin
            we = 1'b1;
            wdata = nrp_pkg::sadd(rd_a_q, rd_b_q);
          end
          nrp_pkg::OP_SUB: begin
            we = 1'b1;
            wdata = nrp_pkg::sadd(rd_a_q, -rd_b_q);
          end
          nrp_pkg::OP_ADD32: begin
            we = 1'b1;
            wdata = nrp_pkg::sat32(nrp_pkg::sadd(rd_a_q, rd_b_q));
          end
          nrp_pkg::OP_UADD: begin
            we = 1'b1;
            wdata = usum[64] ? nrp_pkg::ALL_ONES : usum[63:0];
          end
          nrp_pkg::OP_MUL: begin
            mul_start = 1'b1;
            state_d = nrp_pkg::S_WAIT;
            pc_d = pc_q;
          end
          nrp_pkg::OP_SQD: begin
            mul_start = 1'b1;
            mul_raw = 1'b1;
            mul_a = diff;
            mul_b = diff;
            sqov_d = diff_mag > 64'h0000_0000_FFFF_FFFF;
            state_d = nrp_pkg::S_WAIT;
            pc_d = pc_q;
          end
          nrp_pkg::OP_DIV: begin
            div_start = 1'b1;
            state_d = nrp_pkg::S_WAIT;
            pc_d = pc_q;
          end
          nrp_pkg::OP_CHKDET: begin
            if (rd_a_q == 64'sd0) begin
              status_d = nrp_pkg::ST_SINGULAR;
              pc_d = nrp_pkg::FIN_PC;
            end
          end
          nrp_pkg::OP_CHKSTEP: begin
            if (64'(rd_a_q) < {16'd0, tol_q}) begin
              status_d = nrp_pkg::ST_CONVERGED;
              pc_d = nrp_pkg::FIN_PC;
            end else begin
              pc_d = '0;
            end
          end
          nrp_pkg::OP_OUTXY: begin
            fin_x_d = rd_a_q[31:0];
            fin_y_d = rd_b_q[31:0];
          end
          nrp_pkg::OP_OUTN: begin
            if (!out_valid_q || out_ch.ready) begin
              out_load = 1'b1;
              state_d = nrp_pkg::S_IDLE;
            end else begin
              state_d = nrp_pkg::S_EXEC;
              pc_d = pc_q;
            end
          end
          default: ;
        endcase
      end
      nrp_pkg::S_WAIT: begin
        if (uop.op == nrp_pkg::OP_DIV) begin
          wdata = div_res;
          if (div_st.done) begin
            we = 1'b1;
            state_d = nrp_pkg::S_FETCH;
            pc_d = pc_q + nrp_pkg::PC_W'(1);
          end
        end else begin
          wdata = (uop.op == nrp_pkg::OP_SQD && sqov_q) ? nrp_pkg::ALL_ONES : mul_res;
          if (mul_st.done) begin
            we = 1'b1;
            state_d = nrp_pkg::S_FETCH;
            pc_d = pc_q + nrp_pkg::PC_W'(1);
          end
        end
      end
      default: state_d = nrp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q <= fin_x_q;
      out_y_q <= fin_y_q;
      out_used_q <= used_q;
      out_status_q <= status_q;
      out_degen_q <= degen;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.result_x = out_x_q;
  assign out_ch.result_y = out_y_q;
  assign out_ch.iterations_used = out_used_q;
  assign out_ch.finish_status = out_status_q;
  assign out_ch.degenerate = out_degen_q;

`ifndef SYNTHESIS
  a_mul_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy) else $error("multiplier started while busy");
  a_wait_has_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrp_pkg::S_WAIT) |-> (mul_st.busy || div_st.busy))
    else $error("sequencer waits on an idle unit");
  a_load_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrp_pkg::S_LOAD) |-> (!mul_st.busy && !div_st.busy))
    else $error("arithmetic unit busy during load");
`endif

endmodule
`default_nettype wire

// ----- hdl/nrp_fmul.sv -----
// Multi-cycle fixed-point multiplier built from four 32x32 partial products.
`default_nettype none
module nrp_fmul #(
  parameter int FRAC_BITS = nrp_pkg::FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic raw_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic signed [63:0] result_o,
  output nrp_pkg::unit_stat_t stat_o
);

  localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

  logic busy_q;
  logic [2:0] cnt_q;
  logic [63:0] ma_q, mb_q;
  logic neg_q, raw_q;
  logic [63:0] pp_q;
  logic [1:0] sh_q;
  logic [127:0] acc_q, rnd_q;
  logic [31:0] pa, pb;
  logic [1:0] sh;
  logic [63:0] mfix;
  logic ovf;

  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin pa = ma_q[31:0];  pb = mb_q[31:0];  sh = 2'd0; end
      2'd1: begin pa = ma_q[31:0];  pb = mb_q[63:32]; sh = 2'd1; end
      2'd2: begin pa = ma_q[63:32]; pb = mb_q[31:0];  sh = 2'd1; end
      default: begin pa = ma_q[63:32]; pb = mb_q[63:32]; sh = 2'd2; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 3'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd6) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q <= nrp_pkg::mag64(a_i);
      mb_q <= nrp_pkg::mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      raw_q <= raw_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q <= 3'd3) begin
        pp_q <= pa * pb;
        sh_q <= sh;
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
      end
      if (cnt_q == 3'd5) begin
        rnd_q <= raw_q ? acc_q : acc_q + RND;
      end
    end
  end

  assign mfix = 64'(rnd_q >> FRAC_BITS);
  assign ovf = (rnd_q >> (FRAC_BITS + 64)) != 128'd0;
  assign result_o = raw_q ? $signed(rnd_q[63:0])
                  : nrp_pkg::sat_mag(ovf ? nrp_pkg::ALL_ONES : mfix, neg_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == 3'd6);

endmodule
`default_nettype wire

// ----- hdl/nrp_fdiv.sv -----
// Restoring fixed-point divider that produces one quotient bit per cycle.
`default_nettype none
module nrp_fdiv #(
  parameter int FRAC_BITS = nrp_pkg::FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic signed [63:0] n_i,
  input  wire logic signed [63:0] d_i,
  output logic signed [63:0] result_o,
  output nrp_pkg::unit_stat_t stat_o
);

  logic busy_q;
  logic [7:0] cnt_q;
  logic [127:0] dvd_q;
  logic [63:0] rem_q;
  logic [63:0] quo_q, md_q;
  logic over_q, neg_q;
  logic [64:0] trial;
  logic qbit;

  assign trial = {rem_q, dvd_q[127]};
  assign qbit = trial >= {1'b0, md_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 8'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 8'd0;
    end else if (busy_q) begin
      if (cnt_q[7]) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {64'd0, nrp_pkg::mag64(n_i)} << FRAC_BITS;
      md_q <= nrp_pkg::mag64(d_i);
      neg_q <= n_i[63] ^ d_i[63];
      rem_q <= 64'd0;
      quo_q <= 64'd0;
      over_q <= 1'b0;
    end else if (busy_q && !cnt_q[7]) begin
      rem_q <= qbit ? 64'(trial - {1'b0, md_q}) : trial[63:0];
      quo_q <= {quo_q[62:0], qbit};
      dvd_q <= {dvd_q[126:0], 1'b0};
      if (qbit && !cnt_q[6]) begin
        over_q <= 1'b1;
      end
    end
  end

  assign result_o = nrp_pkg::sat_mag(over_q ? nrp_pkg::ALL_ONES : quo_q, neg_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && cnt_q[7];

endmodule
`default_nettype wire

// ----- test/newton_rank1_projection_2x2_tb.sv -----
// Testbench for the rank-one Newton projection block: a bit-exact predictor checked against every result.
`timescale 1ns / 100ps
`default_nettype none
module newton_rank1_projection_2x2_tb;

  typedef struct packed {
    logic signed [31:0] a, b, c, d, x, y;
  } matrix_item_t;

  typedef struct packed {
    logic signed [31:0] rx, ry;
    logic [11:0] iters;
    logic [1:0] status;
    logic degen;
  } projection_t;

  localparam logic signed [63:0] MAXW = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 64'd100_000_000;
  localparam int HOLD_CYCLES = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = nrp_pkg::CFG_MAX_ITER;
  logic [47:0] cfg_wdata_i = '0;

  nrp_in_if in_ch ();
  nrp_out_if out_ch ();

  newton_rank1_projection_2x2 uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [11:0] iter_limit = nrp_pkg::MAX_ITER_RST;
  logic [47:0] step_tol = nrp_pkg::STEP_TOL_RST;
  logic [47:0] norm_lim = nrp_pkg::NORM_LIM_RST;

  matrix_item_t pending_q[$];
  projection_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int converged_seen = 0, limit_seen = 0, singular_seen = 0, degen_seen = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;

  function automatic logic [63:0] magn(logic signed [63:0] v);
    return v[63] ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] from_mag(logic [63:0] m, bit neg);
    logic signed [63:0] r;
    r = (m > 64'(MAXW)) ? MAXW : $signed(m);
    return neg ? -r : r;
  endfunction

  function automatic logic signed [63:0] s_add(logic signed [63:0] p, logic signed [63:0] q);
    logic signed [64:0] s;
    s = 65'(p) + 65'(q);
    if (s > 65'(MAXW)) return MAXW;
    if (s < -65'(MAXW)) return -MAXW;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] s_sub(logic signed [63:0] p, logic signed [63:0] q);
    return s_add(p, -q);
  endfunction

  function automatic logic signed [63:0] twice(logic signed [63:0] v);
    return s_add(v, v);
  endfunction

  function automatic logic signed [63:0] q_mul(logic signed [63:0] p, logic signed [63:0] q);
    logic [127:0] prod;
    prod = 128'(magn(p)) * 128'(magn(q)) + (128'd1 << (nrp_pkg::FRAC_BITS - 1));
    prod = prod >> nrp_pkg::FRAC_BITS;
    if (prod[127:64] != 0) return from_mag(64'hFFFF_FFFF_FFFF_FFFF, p[63] != q[63]);
    return from_mag(prod[63:0], p[63] != q[63]);
  endfunction

  function automatic logic signed [63:0] q_div(logic signed [63:0] n, logic signed [63:0] d);
    logic [127:0] quo;
    quo = (128'(magn(n)) << nrp_pkg::FRAC_BITS) / 128'(magn(d));
    if (quo[127:64] != 0) return from_mag(64'hFFFF_FFFF_FFFF_FFFF, n[63] != d[63]);
    return from_mag(quo[63:0], n[63] != d[63]);
  endfunction

  function automatic logic signed [63:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] square_sat(logic signed [63:0] v);
    logic [63:0] m;
    m = magn(v);
    if (m > 64'hFFFF_FFFF) return 64'hFFFF_FFFF_FFFF_FFFF;
    return m * m;
  endfunction

  function automatic projection_t project_rank1(matrix_item_t it);
    logic signed [63:0] x, y, xx, yy, xy, ra, rd, bc, g0, g1, h00, h01, h11, det;
    logic signed [63:0] s0, s1, nx, ny;
    logic [63:0] stp, sq;
    logic [11:0] used;
    nrp_pkg::finish_e st;
    projection_t r;
    x = it.x;
    y = it.y;
    used = 0;
    st = nrp_pkg::ST_LIMIT;
    while (used < iter_limit) begin
      used++;
      xx = q_mul(x, x);
      yy = q_mul(y, y);
      xy = q_mul(x, y);
      ra = s_sub(64'(it.a), xx);
      rd = s_sub(64'(it.d), yy);
      bc = s_add(s_sub(64'(it.b), xy), s_sub(64'(it.c), xy));
      g0 = -s_add(twice(twice(q_mul(x, ra))), twice(q_mul(y, bc)));
      g1 = -s_add(twice(q_mul(x, bc)), twice(twice(q_mul(y, rd))));
      h00 = s_add(s_sub(twice(twice(twice(xx))), twice(twice(ra))), twice(twice(yy)));
      h01 = s_sub(twice(twice(xy)), twice(bc));
      h11 = s_sub(s_add(twice(twice(xx)), twice(twice(twice(yy)))), twice(twice(rd)));
      det = s_sub(q_mul(h00, h11), q_mul(h01, h01));
      if (det == 0) begin
        st = nrp_pkg::ST_SINGULAR;
        break;
      end
      s0 = q_div(s_sub(q_mul(g1, h01), q_mul(g0, h11)), det);
      s1 = q_div(s_sub(q_mul(g0, h01), q_mul(g1, h00)), det);
      nx = clip32(s_add(x, s0));
      ny = clip32(s_add(y, s1));
      stp = square_sat(nx - x);
      sq = square_sat(ny - y);
      stp = (stp > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : stp + sq;
      x = nx;
      y = ny;
      if (stp < 64'(step_tol)) begin
        st = nrp_pkg::ST_CONVERGED;
        break;
      end
    end
    sq = 64'(x * x) + 64'(y * y);
    r.rx = x[31:0];
    r.ry = y[31:0];
    r.iters = used;
    r.status = st;
    r.degen = sq < 64'(norm_lim);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: presents queued items with random gaps.
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.entry_00, in_ch.entry_10, in_ch.entry_01, in_ch.entry_11,
       in_ch.start_x, in_ch.start_y} <= '0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(project_rank1(pending_q.pop_front()));
        in_gap = gap_len();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.entry_00, in_ch.entry_10, in_ch.entry_01, in_ch.entry_11,
         in_ch.start_x, in_ch.start_y} <= pending_q[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure and field-by-field check of each transaction.
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      cycles++;
      if (out_ch.valid && out_ch.ready) begin
        projection_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction %0d", results_seen);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.result_x !== e.rx) report_mismatch("result_x", out_ch.result_x, e.rx);
          if (out_ch.result_y !== e.ry) report_mismatch("result_y", out_ch.result_y, e.ry);
          if (out_ch.iterations_used !== e.iters)
            report_mismatch("iterations_used", out_ch.iterations_used, e.iters);
          if (out_ch.finish_status !== e.status)
            report_mismatch("finish_status", out_ch.finish_status, e.status);
          if (out_ch.degenerate !== e.degen)
            report_mismatch("degenerate", out_ch.degenerate, e.degen);
          case (nrp_pkg::finish_e'(e.status))
            nrp_pkg::ST_CONVERGED: converged_seen++;
            nrp_pkg::ST_LIMIT: limit_seen++;
            default: singular_seen++;
          endcase
          degen_seen += e.degen;
        end
        out_gap = gap_len();
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Long receiver stall in the middle of the random part while items keep coming.
  initial begin
    wait (results_seen >= 130);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(nrp_pkg::cfg_idx_e idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      nrp_pkg::CFG_MAX_ITER: iter_limit = val[11:0];
      nrp_pkg::CFG_STEP_TOL: step_tol = val;
      default: norm_lim = val;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_ch.valid) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] q824(int units, int frac);
    return 32'(units) * 32'sd16777216 + 32'(frac);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return q824($urandom_range(0, 6) - 3, $urandom_range(0, 16777215));
      default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
    endcase
  endfunction

  function automatic matrix_item_t well_formed();
    matrix_item_t m;
    logic signed [31:0] u, v;
    u = rand_word();
    v = rand_word();
    m.x = u + $signed($urandom_range(0, 4194303)) - 32'sd2097152;
    m.y = v + $signed($urandom_range(0, 4194303)) - 32'sd2097152;
    u = u >>> 12;
    v = v >>> 12;
    m.a = (u * u) >>> 0;
    m.a = 32'((64'(u) * 64'(u)) >>> 0);
    m.b = 32'(64'(u) * 64'(v));
    m.c = m.b + $signed($urandom_range(0, 65535)) - 32'sd32768;
    m.d = 32'(64'(v) * 64'(v));
    return m;
  endfunction

  function automatic matrix_item_t any_item();
    matrix_item_t m;
    m = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    return m;
  endfunction

  initial begin
    matrix_item_t m;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(nrp_pkg::CFG_MAX_ITER, 48'd20);
    // Directed part: identity, zero matrix (singular), extremes, zero start.
    pending_q.push_back({q824(1, 0), 32'sd0, 32'sd0, q824(1, 0), q824(1, 0), q824(0, 100)});
    pending_q.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_q.push_back({q824(4, 0), q824(2, 0), q824(2, 0), q824(1, 0),
                         q824(1, 0), q824(1, 0)});
    pending_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000});
    pending_q.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h7FFF_FFFF});
    pending_q.push_back({32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF});
    pending_q.push_back({q824(-1, 0), 32'sd0, 32'sd0, q824(-1, 0), q824(0, 5), q824(0, 7)});
    pending_q.push_back({q824(1, 0), 32'sd0, 32'sd0, q824(1, 0), 32'sd0, 32'sd0});
    for (int i = 0; i < 6; i++) pending_q.push_back(well_formed());
    drain();
    write_reg(nrp_pkg::CFG_MAX_ITER, 48'd0);
    write_reg(nrp_pkg::CFG_NORM_LIM, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 4; i++) pending_q.push_back(any_item());
    drain();
    write_reg(nrp_pkg::CFG_MAX_ITER, 48'd4095);
    write_reg(nrp_pkg::CFG_STEP_TOL, 48'hFFFF_FFFF_FFFF);
    write_reg(nrp_pkg::CFG_NORM_LIM, 48'd0);
    for (int i = 0; i < 4; i++) pending_q.push_back(any_item());
    drain();
    write_reg(nrp_pkg::CFG_MAX_ITER, 48'd1);
    write_reg(nrp_pkg::CFG_STEP_TOL, 48'd0);
    for (int i = 0; i < 4; i++) pending_q.push_back(well_formed());
    drain();
    // Random part, four rounds with random settings; the long output stall falls into the second round.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(nrp_pkg::CFG_MAX_ITER, 48'($urandom_range(1, 12)));
      write_reg(nrp_pkg::CFG_STEP_TOL, ph[0] ? 48'($urandom()) : nrp_pkg::STEP_TOL_RST);
      write_reg(nrp_pkg::CFG_NORM_LIM, {16'd0, 32'($urandom())} >> $urandom_range(0, 16));
      for (int i = 0; i < 70; i++) begin
        m = ($urandom_range(0, 99) < 75) ? well_formed() : any_item();
        pending_q.push_back(m);
      end
      drain();
    end
    write_reg(nrp_pkg::CFG_MAX_ITER, 48'd500);
    write_reg(nrp_pkg::CFG_STEP_TOL, nrp_pkg::STEP_TOL_RST);
    write_reg(nrp_pkg::CFG_NORM_LIM, nrp_pkg::NORM_LIM_RST);
    for (int i = 0; i < 10; i++) pending_q.push_back(well_formed());
    drain();
    $display("%0d results checked: %0d converged, %0d at limit, %0d singular, %0d degenerate",
             results_seen, converged_seen, limit_seen, singular_seen, degen_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/nrp_pkg.sv
hdl/nrp_if.sv
hdl/nrp_fmul.sv
hdl/nrp_fdiv.sv
hdl/newton_rank1_projection_2x2.sv
test/newton_rank1_projection_2x2_tb.sv
